// File: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants for the line rasterizer
// Beat layouts for the command and pixel channels, command codes and step
// direction codes.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 24;

    // command codes
    localparam logic CMD_BEGIN   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // step direction codes (two's complement of -1, 0, +1)
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] pixel_color;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] out_color;
        logic               last_pixel;
        logic               no_pixel;
    } t_out_item;

endpackage

// File: rtl/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line generator
// Begin beats set up a line and return its start pixel; advance beats walk
// the line one pixel at a time, or return a no-pixel beat when no line is active.
// ----------------------------------------------------------------------------
// A command beat gives its pixel beat in the next cycle (one result register).
// Throughput: 1 command per cycle while the pixel side takes each beat; set by
//   the single decision add/compare between the line state registers and the result register.
// Input ready stays high while the result register is empty or being taken.
// Reset (synchronous, active low) empties the output and drops any line.
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CW = COORD_BITS;     // coordinate width
    localparam int TW = COORD_BITS + 2; // doubled delta width
    localparam int DW = COORD_BITS + 3; // decision term width (signed)
    localparam int SW = COORD_BITS + 1; // step counter width

    // step a coordinate by one in the given direction, wrapping
    function automatic logic [CW-1:0] move_coord(input logic [CW-1:0] c,
                                                 input logic [1:0]    dir);
        logic [CW-1:0] res;
        res = c;
        if (dir == DIR_POS) begin
            res = c + CW'(1);
        end else if (dir == DIR_NEG) begin
            res = c - CW'(1);
        end
        return res;
    endfunction

    // line state
    logic [CW-1:0]    r_cur_x, n_cur_x;
    logic [CW-1:0]    r_cur_y, n_cur_y;
    logic [DW-1:0]    r_decision, n_decision;
    logic [TW-1:0]    r_twice_minor, n_twice_minor;
    logic [TW-1:0]    r_twice_major, n_twice_major;
    logic [SW-1:0]    r_steps_left, n_steps_left;
    logic [1:0]       r_x_dir, n_x_dir;
    logic [1:0]       r_y_dir, n_y_dir;
    logic             r_x_major, n_x_major;
    logic             r_active, n_active;
    logic [COLOR_W-1:0] r_color, n_color;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item, n_out_item;

    logic in_fire;

    // begin setup terms
    logic [CW-1:0] sx, sy, ex, ey, dx, dy, major, minor, mx, my;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign sx = CW'(i_in_item.start_x);
    assign sy = CW'(i_in_item.start_y);
    assign ex = CW'(i_in_item.end_x);
    assign ey = CW'(i_in_item.end_y);
    assign dx = (ex > sx) ? ex - sx : sx - ex;
    assign dy = (ey > sy) ? ey - sy : sy - ey;
    assign major = (dx > dy) ? dx : dy;
    assign minor = (dx > dy) ? dy : dx;

    // next state and result
    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_decision    = r_decision;
        n_twice_minor = r_twice_minor;
        n_twice_major = r_twice_major;
        n_steps_left  = r_steps_left;
        n_x_dir       = r_x_dir;
        n_y_dir       = r_y_dir;
        n_x_major     = r_x_major;
        n_active      = r_active;
        n_color       = r_color;
        n_out_item    = '0;
        mx            = r_cur_x;
        my            = r_cur_y;

        if (i_in_item.command == CMD_BEGIN) begin
            n_x_dir       = (ex > sx) ? DIR_POS : ((ex == sx) ? DIR_NONE : DIR_NEG);
            n_y_dir       = (ey > sy) ? DIR_POS : ((ey == sy) ? DIR_NONE : DIR_NEG);
            n_x_major     = dx > dy;
            n_twice_major = TW'({major, 1'b0});
            n_twice_minor = TW'({minor, 1'b0});
            n_decision    = DW'({minor, 1'b0}) - DW'(major);
            n_steps_left  = SW'(major);
            n_cur_x       = sx;
            n_cur_y       = sy;
            n_color       = i_in_item.pixel_color;
            n_active      = major != '0;
            n_out_item.pixel_x    = COORD_W'(sx);
            n_out_item.pixel_y    = COORD_W'(sy);
            n_out_item.out_color  = i_in_item.pixel_color;
            n_out_item.last_pixel = major == '0;
        end else if (!r_active) begin
            n_out_item.no_pixel = 1'b1;
        end else begin
            // minor axis steps on a non-negative decision term
            if (r_decision[DW-1]) begin
                n_decision = r_decision + DW'(r_twice_minor);
            end else begin
                n_decision = r_decision + DW'(r_twice_minor) - DW'(r_twice_major);
                if (r_x_major) begin
                    my = move_coord(r_cur_y, r_y_dir);
                end else begin
                    mx = move_coord(r_cur_x, r_x_dir);
                end
            end
            // major axis always steps
            if (r_x_major) begin
                mx = move_coord(r_cur_x, r_x_dir);
            end else begin
                my = move_coord(r_cur_y, r_y_dir);
            end
            n_cur_x      = mx;
            n_cur_y      = my;
            n_steps_left = r_steps_left - SW'(1);
            n_active     = n_steps_left != '0;
            n_out_item.pixel_x    = COORD_W'(mx);
            n_out_item.pixel_y    = COORD_W'(my);
            n_out_item.out_color  = r_color;
            n_out_item.last_pixel = n_steps_left == '0;
        end
    end

    // state update on accepted command beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_decision    <= '0;
            r_twice_minor <= '0;
            r_twice_major <= '0;
            r_steps_left  <= '0;
            r_x_dir       <= DIR_NONE;
            r_y_dir       <= DIR_NONE;
            r_x_major     <= 1'b0;
            r_active      <= 1'b0;
            r_color       <= '0;
        end else if (in_fire) begin
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_decision    <= n_decision;
            r_twice_minor <= n_twice_minor;
            r_twice_major <= n_twice_major;
            r_steps_left  <= n_steps_left;
            r_x_dir       <= n_x_dir;
            r_y_dir       <= n_y_dir;
            r_x_major     <= n_x_major;
            r_active      <= n_active;
            r_color       <= n_color;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/lr_checker.sv
// ----------------------------------------------------------------------------
// lr_checker: port-level checks for the line rasterizer
// Watches both channels and the pixel beats; bound into line_rasterizer.
// ----------------------------------------------------------------------------
module lr_checker
    import lr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic in_fire;
    assign in_fire = i_in_valid && o_in_ready;

    // a stalled pixel beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("pixel beat changed while stalled");

    // every command beat gives a pixel beat in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out_valid)
        else $error("no pixel beat after command beat");

    // a begin always returns a real pixel in the new color
    a_begin_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_item.command == CMD_BEGIN |=>
            !o_out_item.no_pixel && o_out_item.out_color == $past(i_in_item.pixel_color))
        else $error("begin did not return its start pixel");

    // an empty advance carries zero fields
    a_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.no_pixel |->
            o_out_item.pixel_x == '0 && o_out_item.pixel_y == '0
            && o_out_item.out_color == '0 && !o_out_item.last_pixel)
        else $error("no-pixel beat carries data");

    // after a last pixel, an advance with nothing in between finds no line
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_pixel && in_fire
            && i_in_item.command == CMD_ADVANCE && $past(in_fire) |=>
            o_out_item.no_pixel)
        else $error("line continued past its last pixel");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Bresenham line rasterizer
// A queue of begin and advance command beats is built up front: a short
// directed set (idle advances, single-point line, full-screen diagonal, a
// line dropped by a new begin, decision ties) and then random lines, mostly
// short and fully walked, with a few long ones cut short. Each accepted beat
// runs through a line-walk model to give the expected pixel, and each pixel
// beat is checked field by field. Both sides idle at random, and the pixel
// side holds off twice for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
    import lr_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 11;
    localparam int CMD_TARGET   = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_COORD    = (1 << COORD_W) - 1;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  in_item  = '0;
    logic      o_out_valid;
    logic      out_ready = 1'b0;
    t_out_item o_out_item;

    line_rasterizer #(
        .COORD_BITS (COORD_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    // command beats waiting to go out, pixels still owed by the block
    t_in_item  pending_cmds[$];
    t_out_item expected_pixels[$];

    int errors      = 0;
    int cycle_count = 0;
    int cmds_taken  = 0;
    int hold_left   = 0;
    int holds_done  = 0;
    int tx_gap      = 0;
    int tx_calm     = 0;
    int rx_gap      = 0;
    int rx_calm     = 0;

    // line-walk model state
    logic [COORD_W-1:0] pos_x, pos_y;
    logic signed [14:0] err_term;
    logic [13:0]        minor2, major2;
    logic [12:0]        remaining;
    logic [1:0]         x_dir, y_dir;
    logic               x_major;
    logic               drawing;
    logic [COLOR_W-1:0] line_rgb;

    t_out_item want_px;

    // clock and reset
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    task automatic note_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // four-state compare so that unknown bits show up as mismatches
    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            note_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int draw_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 62) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COORD_W-1:0] step_coord(logic [COORD_W-1:0] c,
                                                      logic [1:0] dir);
        case (dir)
            DIR_POS: return c + 1'b1;
            DIR_NEG: return c - 1'b1;
            default: return c;
        endcase
    endfunction

    // expected pixel for one command beat; updates the line state
    function automatic t_out_item raster_step(t_in_item beat);
        t_out_item px;
        int dx, dy, major, minor, err;
        px = '0;
        if (beat.command == CMD_BEGIN) begin
            dx = (beat.end_x > beat.start_x) ? int'(beat.end_x) - int'(beat.start_x)
                                              : int'(beat.start_x) - int'(beat.end_x);
            dy = (beat.end_y > beat.start_y) ? int'(beat.end_y) - int'(beat.start_y)
                                              : int'(beat.start_y) - int'(beat.end_y);
            x_dir = (beat.end_x > beat.start_x) ? DIR_POS :
                    (beat.end_x == beat.start_x) ? DIR_NONE : DIR_NEG;
            y_dir = (beat.end_y > beat.start_y) ? DIR_POS :
                    (beat.end_y == beat.start_y) ? DIR_NONE : DIR_NEG;
            x_major   = dx > dy;
            major     = x_major ? dx : dy;
            minor     = x_major ? dy : dx;
            major2    = 14'(2 * major);
            minor2    = 14'(2 * minor);
            err_term  = 15'(2 * minor - major);
            remaining = 13'(major);
            pos_x     = beat.start_x;
            pos_y     = beat.start_y;
            line_rgb  = beat.pixel_color;
            drawing   = major != 0;
        end else if (!drawing) begin
            px.no_pixel = 1'b1;
            return px;
        end else begin
            // minor axis steps on a non-negative decision term, ties included
            err = int'(err_term);
            if (err < 0) begin
                err += int'(minor2);
            end else begin
                err += int'(minor2) - int'(major2);
                if (x_major) pos_y = step_coord(pos_y, y_dir);
                else         pos_x = step_coord(pos_x, x_dir);
            end
            if (x_major) pos_x = step_coord(pos_x, x_dir);
            else         pos_y = step_coord(pos_y, y_dir);
            err_term  = 15'(err);
            remaining = remaining - 1'b1;
            drawing   = remaining != 0;
        end
        px.pixel_x    = pos_x;
        px.pixel_y    = pos_y;
        px.out_color  = line_rgb;
        px.last_pixel = !drawing;
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_begin(int sx, int sy, int ex, int ey, int rgb);
        t_in_item beat;
        beat.command     = CMD_BEGIN;
        beat.start_x     = COORD_W'(sx);
        beat.start_y     = COORD_W'(sy);
        beat.end_x       = COORD_W'(ex);
        beat.end_y       = COORD_W'(ey);
        beat.pixel_color = COLOR_W'(rgb);
        pending_cmds.push_back(beat);
    endtask

    // advance beats carry random junk in the unused fields
    task automatic push_advance(int count);
        t_in_item beat;
        repeat (count) begin
            beat.command     = CMD_ADVANCE;
            beat.start_x     = COORD_W'($urandom);
            beat.start_y     = COORD_W'($urandom);
            beat.end_x       = COORD_W'($urandom);
            beat.end_y       = COORD_W'($urandom);
            beat.pixel_color = COLOR_W'($urandom);
            pending_cmds.push_back(beat);
        end
    endtask

    // end point within span of the start; an end off the screen is mirrored to the other side of the start
    function automatic int near_coord(int s, int span);
        int ofs, e;
        ofs = $urandom_range(0, span);
        e   = $urandom_range(0, 1) ? s + ofs : s - ofs;
        if (e < 0 || e > MAX_COORD) e = (e < 0) ? s + ofs : s - ofs;
        return e;
    endfunction

    task automatic build_stimulus();
        int sx, sy, ex, ey, span, major, walk, kind;
        // directed: idle advance, single point, diagonal, dropped line, ties
        push_advance(1);
        push_begin(5, 5, 5, 5, 24'hFFFFFF);
        push_advance(1);
        push_begin(0, 0, MAX_COORD, MAX_COORD, 0);
        push_advance(3);
        push_begin(MAX_COORD, 0, 0, 3, 24'h123456);
        push_advance(4);
        push_begin(10, 20, 12, 21, 24'hA5A5A5);
        push_advance(3);
        push_begin(100, 100, 97, 107, 24'h5A5A5A);
        push_advance(7);

        // random lines: mostly short and walked to the end
        while (pending_cmds.size() < CMD_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                push_advance($urandom_range(1, 2));
                continue;
            end
            sx = $urandom_range(0, MAX_COORD);
            sy = $urandom_range(0, MAX_COORD);
            if (kind < 85) span = $urandom_range(0, 12);
            else if (kind < 95) span = $urandom_range(13, 200);
            else span = MAX_COORD;
            ex = near_coord(sx, span);
            ey = near_coord(sy, span);
            push_begin(sx, sy, ex, ey, $urandom);
            major = (ex > sx ? ex - sx : sx - ex);
            if ((ey > sy ? ey - sy : sy - ey) >= major)
                major = (ey > sy ? ey - sy : sy - ey);
            kind = $urandom_range(0, 99);
            if (major > 40) walk = $urandom_range(0, 20);
            else if (kind < 70) walk = major + ($urandom_range(0, 2) == 0);
            else if (kind < 90) walk = $urandom_range(0, major);
            else walk = major + $urandom_range(1, 3);
            push_advance(walk);
        end
    endtask

    // ------------------------------------------------------------------------
    // command driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_pixels.push_back(raster_step(in_item));
                void'(pending_cmds.pop_front());
                cmds_taken <= cmds_taken + 1;
                tx_gap = draw_gap(tx_calm);
            end
            if (in_valid && !o_in_ready) begin
                // hold the beat until taken
            end else if (tx_gap != 0) begin
                in_valid <= 1'b0;
                tx_gap--;
            end else if (pending_cmds.size() != 0) begin
                in_valid <= 1'b1;
                in_item  <= pending_cmds[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // long hold-offs on the pixel side, counted in cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && cmds_taken >= (holds_done + 1) * 200) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------------
    // pixel monitor and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    note_error("pixel beat with no pixel expected");
                end else begin
                    want_px = expected_pixels.pop_front();
                    check_field("pixel_x", 32'(o_out_item.pixel_x),
                                32'(want_px.pixel_x));
                    check_field("pixel_y", 32'(o_out_item.pixel_y),
                                32'(want_px.pixel_y));
                    check_field("out_color", 32'(o_out_item.out_color),
                                32'(want_px.out_color));
                    check_field("last_pixel", 32'(o_out_item.last_pixel),
                                32'(want_px.last_pixel));
                    check_field("no_pixel", 32'(o_out_item.no_pixel),
                                32'(want_px.no_pixel));
                end
                rx_gap = draw_gap(rx_calm);
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                out_ready <= 1'b0;
                rx_gap--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        wait (i_rst_n);
        while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lr_pkg.sv
rtl/line_rasterizer.sv
rtl/lr_checker.sv
dv/tb_top.sv
